[hdl/escape_time_fractal_iterator_top_assert.svh]
// Assertion helpers for the escape-time iterator.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_TOP_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define EFI_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EFI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/efi_pkg.sv]
`timescale 1ns / 1ps
package efi_pkg;

   localparam int ITER_W     = 10;
   localparam int PIX_W      = 16;
   localparam int VAL_W      = 32;
   localparam int COEF_W     = 16;
   localparam int COEF_FRAC  = 12;
   localparam int STEP_W     = 31;
   localparam int VAR_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   // full product of two values, and the common width of every wide sum
   localparam int PROD_W     = 2 * VAL_W;
   localparam int WIDE_W     = 66;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_ITER   = 3'd0,
      CSR_VARIANT    = 3'd1,
      CSR_POWER_COEF = 3'd2,
      CSR_ORIGIN_RE  = 3'd3,
      CSR_ORIGIN_IM  = 3'd4,
      CSR_PIXEL_STEP = 3'd5
   } csr_index_type;

   localparam logic [VAR_W-1:0] VARIANT_MANDEL  = 2'd0;
   localparam logic [VAR_W-1:0] VARIANT_SHIP    = 2'd1;
   localparam logic [VAR_W-1:0] VARIANT_TRICORN = 2'd2;

   localparam logic [ITER_W-1:0]       RST_MAX_ITER   = 10'd100;
   localparam logic [VAR_W-1:0]        RST_VARIANT    = VARIANT_MANDEL;
   localparam logic [COEF_W-1:0]       RST_POWER_COEF = 16'd8192;
   localparam logic signed [VAL_W-1:0] RST_ORIGIN_RE  = -32'sd134217728;
   localparam logic signed [VAL_W-1:0] RST_ORIGIN_IM  = -32'sd67108864;
   localparam logic [STEP_W-1:0]       RST_PIXEL_STEP = 31'd225874;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_x;
      logic [PIX_W-1:0] pixel_y;
   } req_payload_type;

   typedef struct packed {
      logic [ITER_W-1:0] iteration_count;
      logic              in_set;
   } rsp_payload_type;

   typedef struct packed {
      logic [ITER_W-1:0]       max_iterations;
      logic [VAR_W-1:0]        variant;
      logic [COEF_W-1:0]       power_coef;
      logic signed [VAL_W-1:0] origin_re;
      logic signed [VAL_W-1:0] origin_im;
      logic [STEP_W-1:0]       pixel_step;
   } csr_regs_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMUL,
      ST_CADD,
      ST_SQUARE,
      ST_UPDATE,
      ST_FINISH
   } efi_state_type;

   typedef struct packed {
      logic load_pixel;
      logic c_mul;
      logic c_add;
      logic square;
      logic update;
      logic emit;
   } efi_cmd_type;

   typedef struct packed {
      logic limit_zero;
      logic escape;
      logic last_iter;
      logic out_free;
   } efi_status_type;

   // clamp a wide signed value into the 32-bit value range
   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-VAL_W:0] upper;
      upper = v[WIDE_W-1:VAL_W-1];
      if (upper == '0 || upper == '1) begin
         return v[VAL_W-1:0];
      end else if (v[WIDE_W-1]) begin
         return {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         return {1'b0, {(VAL_W-1){1'b1}}};
      end
   endfunction

endpackage

[hdl/escape_time_fractal_iterator_top.sv]
// Sequence: a taken request runs the c multiply and c add, then one square/update pair
//   per iteration; a pixel that escapes runs one more pair for the escape test.
// Requests: a new request is taken only once the controller is back in idle; the previous
//   result may still wait. The squaring multipliers and update stage are shared by all iterations.
// Reset: synchronous, active high; registers return to defaults, controller to idle.
`timescale 1ns / 1ps
`include "escape_time_fractal_iterator_top_assert.svh"
module escape_time_fractal_iterator_top #(
   parameter int FRAC_BITS  = 26,   // fraction bits of the value format
   parameter int COUNT_BITS = 10    // iteration counter width
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel: one pixel coordinate pair
   input  logic                            req_valid,
   output logic                            req_stall,
   input  efi_pkg::req_payload_type        req_payload,
   // result channel: iteration count and in-set flag
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output efi_pkg::rsp_payload_type        rsp_payload,
   // register writes, only while idle
   input  logic                            csr_wr_en,
   input  logic [efi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [efi_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   efi_pkg::csr_regs_type   csr_regs;
   efi_pkg::efi_cmd_type    cmd;
   efi_pkg::efi_status_type status;

   // max_iterations, variant, power_coef, origin, pixel_step
   efi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (csr_regs)
   );

   // sequencer: idle -> c multiply -> c add -> (square -> update)* -> finish
   efi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // z/c registers, multipliers, saturating adders, counter and result register.
   // The result register lets a new request in while the previous result waits.
   efi_dpath #(
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .regs        (csr_regs),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // a taken request keeps the block busy for at least the c setup
   `EFI_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall,
      "request taken but block not busy")
   // a result leaves only through a completed handshake
   `EFI_ASSERT_HOLDS(a_rsp_drop, clock, reset, $fell(rsp_valid), $past(!rsp_stall),
      "result dropped while stalled")
   // an escaped pixel stops short of the limit
   `EFI_ASSERT_HOLDS(a_escape_count, clock, reset, rsp_valid && !rsp_payload.in_set,
      rsp_payload.iteration_count < csr_regs.max_iterations, "escaped count not below limit")

endmodule

[hdl/efi_csr.sv]
`timescale 1ns / 1ps
module efi_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [efi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [efi_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output efi_pkg::csr_regs_type            regs
);

   efi_pkg::csr_regs_type regs_ff, regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            efi_pkg::CSR_MAX_ITER:   regs_in.max_iterations = csr_wdata[efi_pkg::ITER_W-1:0];
            efi_pkg::CSR_VARIANT:    regs_in.variant        = csr_wdata[efi_pkg::VAR_W-1:0];
            efi_pkg::CSR_POWER_COEF: regs_in.power_coef     = csr_wdata[efi_pkg::COEF_W-1:0];
            efi_pkg::CSR_ORIGIN_RE:  regs_in.origin_re      = csr_wdata[efi_pkg::VAL_W-1:0];
            efi_pkg::CSR_ORIGIN_IM:  regs_in.origin_im      = csr_wdata[efi_pkg::VAL_W-1:0];
            efi_pkg::CSR_PIXEL_STEP: regs_in.pixel_step     = csr_wdata[efi_pkg::STEP_W-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.max_iterations <= efi_pkg::RST_MAX_ITER;
         regs_ff.variant        <= efi_pkg::RST_VARIANT;
         regs_ff.power_coef     <= efi_pkg::RST_POWER_COEF;
         regs_ff.origin_re      <= efi_pkg::RST_ORIGIN_RE;
         regs_ff.origin_im      <= efi_pkg::RST_ORIGIN_IM;
         regs_ff.pixel_step     <= efi_pkg::RST_PIXEL_STEP;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

[hdl/efi_ctrl.sv]
`timescale 1ns / 1ps
module efi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  efi_pkg::efi_status_type status,
   output efi_pkg::efi_cmd_type    cmd
);

   efi_pkg::efi_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         efi_pkg::ST_IDLE:   if (req_valid) state_in = efi_pkg::ST_CMUL;
         efi_pkg::ST_CMUL:   state_in = efi_pkg::ST_CADD;
         efi_pkg::ST_CADD: begin
            state_in = status.limit_zero ? efi_pkg::ST_FINISH : efi_pkg::ST_SQUARE;
         end
         efi_pkg::ST_SQUARE: state_in = efi_pkg::ST_UPDATE;
         efi_pkg::ST_UPDATE: begin
            state_in = (status.escape || status.last_iter) ? efi_pkg::ST_FINISH
                                                          : efi_pkg::ST_SQUARE;
         end
         efi_pkg::ST_FINISH: if (status.out_free) state_in = efi_pkg::ST_IDLE;
         default:            state_in = efi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall      = (state_ff != efi_pkg::ST_IDLE);
      cmd.load_pixel = (state_ff == efi_pkg::ST_IDLE) && req_valid;
      cmd.c_mul      = (state_ff == efi_pkg::ST_CMUL);
      cmd.c_add      = (state_ff == efi_pkg::ST_CADD);
      cmd.square     = (state_ff == efi_pkg::ST_SQUARE);
      cmd.update     = (state_ff == efi_pkg::ST_UPDATE) && !status.escape;
      cmd.emit       = (state_ff == efi_pkg::ST_FINISH) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= efi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/efi_dpath.sv]
`timescale 1ns / 1ps
module efi_dpath #(
   parameter int FRAC_BITS  = 26,
   parameter int COUNT_BITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  efi_pkg::efi_cmd_type      cmd,
   output efi_pkg::efi_status_type   status,
   input  efi_pkg::csr_regs_type     regs,
   input  efi_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output efi_pkg::rsp_payload_type  rsp_payload
);

   localparam int VW      = efi_pkg::VAL_W;
   localparam int WW      = efi_pkg::WIDE_W;
   localparam int IW      = efi_pkg::ITER_W;
   localparam int CPROD_W = efi_pkg::PIX_W + efi_pkg::STEP_W;
   localparam int SQ_W    = efi_pkg::PROD_W - FRAC_BITS;          // shifted square / cross
   localparam int TP_W    = SQ_W + efi_pkg::COEF_W + 1;           // cross times coef
   localparam logic signed [WW-1:0] BOUND = WW'(4) <<< FRAC_BITS;

   efi_pkg::req_payload_type pix_ff;
   logic [CPROD_W-1:0]       cprod_re_ff, cprod_re_in, cprod_im_ff, cprod_im_in;
   logic signed [VW-1:0]     c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic signed [VW-1:0]     z_re_ff, z_re_in, z_im_ff, z_im_in;
   logic signed [SQ_W-1:0]   rr_ff, ii_ff, xy_ff;
   logic [COUNT_BITS-1:0]    count_ff, count_in, limit;
   logic                     rsp_valid_ff, rsp_valid_in;
   efi_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic signed [efi_pkg::PROD_W-1:0] p_rr, p_ii, p_xy, s_rr, s_ii, s_xy;
   logic signed [efi_pkg::COEF_W:0]   coef_s;
   logic signed [TP_W-1:0]            t_prod, t_sh;
   logic signed [WW-1:0]              rr_w, ii_w, t_w, t_mod, sq_sum;

   assign limit = COUNT_BITS'(regs.max_iterations);

   // c = origin + pixel * step
   assign cprod_re_in = CPROD_W'(pix_ff.pixel_x) * CPROD_W'(regs.pixel_step);
   assign cprod_im_in = CPROD_W'(pix_ff.pixel_y) * CPROD_W'(regs.pixel_step);
   assign c_re_in = efi_pkg::sat_val({{(WW-VW){regs.origin_re[VW-1]}}, regs.origin_re}
                                     + {{(WW-CPROD_W){1'b0}}, cprod_re_ff});
   assign c_im_in = efi_pkg::sat_val({{(WW-VW){regs.origin_im[VW-1]}}, regs.origin_im}
                                     + {{(WW-CPROD_W){1'b0}}, cprod_im_ff});

   // squaring stage
   assign p_rr = z_re_ff * z_re_ff;
   assign p_ii = z_im_ff * z_im_ff;
   assign p_xy = z_re_ff * z_im_ff;
   assign s_rr = p_rr >>> FRAC_BITS;
   assign s_ii = p_ii >>> FRAC_BITS;
   assign s_xy = p_xy >>> FRAC_BITS;

   // update stage
   assign coef_s = {1'b0, regs.power_coef};
   assign t_prod = xy_ff * coef_s;
   assign t_sh   = t_prod >>> efi_pkg::COEF_FRAC;
   assign rr_w   = {{(WW-SQ_W){rr_ff[SQ_W-1]}}, rr_ff};
   assign ii_w   = {{(WW-SQ_W){ii_ff[SQ_W-1]}}, ii_ff};
   assign t_w    = {{(WW-TP_W){t_sh[TP_W-1]}}, t_sh};
   assign sq_sum = rr_w + ii_w;

   always_comb begin
      t_mod = t_w;
      if (regs.variant == efi_pkg::VARIANT_SHIP && t_w[WW-1]) begin
         t_mod = -t_w;
      end else if (regs.variant == efi_pkg::VARIANT_TRICORN) begin
         t_mod = -t_w;
      end
   end

   always_comb begin
      z_re_in  = z_re_ff;
      z_im_in  = z_im_ff;
      count_in = count_ff;
      if (cmd.c_add) begin
         z_re_in  = '0;
         z_im_in  = '0;
         count_in = '0;
      end else if (cmd.update) begin
         z_re_in  = efi_pkg::sat_val(rr_w - ii_w + {{(WW-VW){c_re_ff[VW-1]}}, c_re_ff});
         z_im_in  = efi_pkg::sat_val(t_mod + {{(WW-VW){c_im_ff[VW-1]}}, c_im_ff});
         count_in = count_ff + 1'b1;
      end
   end

   // result register
   assign rsp_payload_in.iteration_count = IW'(count_ff);
   assign rsp_payload_in.in_set          = (count_ff == limit);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.limit_zero = (limit == '0);
   assign status.escape     = (sq_sum > BOUND);
   assign status.last_iter  = ((count_ff + 1'b1) == limit);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         pix_ff <= req_payload;
      end
      if (cmd.c_mul) begin
         cprod_re_ff <= cprod_re_in;
         cprod_im_ff <= cprod_im_in;
      end
      if (cmd.c_add) begin
         c_re_ff <= c_re_in;
         c_im_ff <= c_im_in;
      end
      if (cmd.square) begin
         rr_ff <= s_rr[SQ_W-1:0];
         ii_ff <= s_ii[SQ_W-1:0];
         xy_ff <= s_xy[SQ_W-1:0];
      end
      if (cmd.emit) begin
         rsp_payload_ff <= rsp_payload_in;
      end
      z_re_ff  <= z_re_in;
      z_im_ff  <= z_im_in;
      count_ff <= count_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[test/escape_time_fractal_iterator_top_test.sv]
`timescale 1ns / 1ps
module escape_time_fractal_iterator_top_test;

   // Value format of the DUT at its default parameters (Q5.26 in 32 bits).
   localparam int     FRAC         = 26;
   localparam longint VAL_MAX      = (longint'(1) <<< (efi_pkg::VAL_W - 1)) - 1;
   localparam longint VAL_MIN      = -(longint'(1) <<< (efi_pkg::VAL_W - 1));
   localparam longint ESCAPE_BOUND = longint'(4) <<< FRAC;

   // Register indexes with no register behind them; writes there are dropped.
   localparam logic [efi_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_A = 3'd6;
   localparam logic [efi_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_B = 3'd7;
   // Spare variant code, treated as plain mandelbrot.
   localparam logic [efi_pkg::VAR_W-1:0]     VARIANT_SPARE  = 2'd3;

   // Cycles to let pass after the last result before touching registers.
   localparam int SETTLE_CYCLES = 8;
   // Hard stop, well above the slowest legal run.
   localparam int TIMEOUT_NS    = 50_000_000;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   efi_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   efi_pkg::rsp_payload_type rsp_payload;
   logic                              csr_wr_en = 1'b0;
   logic [efi_pkg::CSR_IDX_W-1:0]     csr_index = efi_pkg::CSR_MAX_ITER;
   logic [efi_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   // Shadow copy of the register file, updated on every write we issue.
   logic [efi_pkg::ITER_W-1:0]       cfg_max_iter  = efi_pkg::RST_MAX_ITER;
   logic [efi_pkg::VAR_W-1:0]        cfg_variant   = efi_pkg::RST_VARIANT;
   logic [efi_pkg::COEF_W-1:0]       cfg_coef      = efi_pkg::RST_POWER_COEF;
   logic signed [efi_pkg::VAL_W-1:0] cfg_origin_re = efi_pkg::RST_ORIGIN_RE;
   logic signed [efi_pkg::VAL_W-1:0] cfg_origin_im = efi_pkg::RST_ORIGIN_IM;
   logic [efi_pkg::STEP_W-1:0]       cfg_step      = efi_pkg::RST_PIXEL_STEP;

   // Predicted count/in-set results, oldest request first.
   efi_pkg::rsp_payload_type expected_counts[$];
   int                       mismatch_count  = 0;

   // Knobs shared with the result-side backpressure process.
   bit steady_flow     = 1'b0;  // no gaps, no stalls
   int hold_off_cycles = 0;     // one long stall of this many cycles

   escape_time_fractal_iterator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("escape_time_fractal_iterator_top_test: errors");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic longint clamp_val(input longint v);
      if (v > VAL_MAX) return VAL_MAX;
      if (v < VAL_MIN) return VAL_MIN;
      return v;
   endfunction

   // Escape-time count of one pixel under the current register shadow.
   // All shifts are arithmetic (floor); every c and z value saturates.
   function automatic efi_pkg::rsp_payload_type escape_count(
         input logic [efi_pkg::PIX_W-1:0] px,
         input logic [efi_pkg::PIX_W-1:0] py);
      longint                   cre, cim, zre, zim, rr, ii, xy, t;
      int                       n;
      efi_pkg::rsp_payload_type r;
      cre = clamp_val(longint'(cfg_origin_re) + longint'(px) * longint'(cfg_step));
      cim = clamp_val(longint'(cfg_origin_im) + longint'(py) * longint'(cfg_step));
      zre = 0;
      zim = 0;
      n   = 0;
      while (n < int'(cfg_max_iter)) begin
         rr = (zre * zre) >>> FRAC;
         ii = (zim * zim) >>> FRAC;
         // escape is tested before each iteration only
         if (rr + ii > ESCAPE_BOUND) break;
         xy = (zre * zim) >>> FRAC;
         t  = (xy * longint'(cfg_coef)) >>> efi_pkg::COEF_FRAC;
         if (cfg_variant == efi_pkg::VARIANT_SHIP && t < 0) begin
            t = -t;
         end else if (cfg_variant == efi_pkg::VARIANT_TRICORN) begin
            t = -t;
         end
         zre = clamp_val(rr - ii + cre);
         zim = clamp_val(t + cim);
         n++;
      end
      r.iteration_count = efi_pkg::ITER_W'(n);
      r.in_set          = (n == int'(cfg_max_iter));
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Shared helpers
   // ------------------------------------------------------------------

   task automatic flag_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   // Mostly inside a 256x256 frame, sometimes anywhere in the 16-bit range.
   function automatic logic [efi_pkg::PIX_W-1:0] random_pixel();
      if ($urandom_range(0, 99) < 85) return efi_pkg::PIX_W'($urandom_range(0, 255));
      return efi_pkg::PIX_W'($urandom_range(0, 65535));
   endfunction

   // Called at a rising edge. Returns with the write enable low again.
   task automatic write_csr(input logic [efi_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [efi_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      unique case (idx)
         efi_pkg::CSR_MAX_ITER:   cfg_max_iter  = data[efi_pkg::ITER_W-1:0];
         efi_pkg::CSR_VARIANT:    cfg_variant   = data[efi_pkg::VAR_W-1:0];
         efi_pkg::CSR_POWER_COEF: cfg_coef      = data[efi_pkg::COEF_W-1:0];
         efi_pkg::CSR_ORIGIN_RE:  cfg_origin_re = data[efi_pkg::VAL_W-1:0];
         efi_pkg::CSR_ORIGIN_IM:  cfg_origin_im = data[efi_pkg::VAL_W-1:0];
         efi_pkg::CSR_PIXEL_STEP: cfg_step      = data[efi_pkg::STEP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_defaults();
      write_csr(efi_pkg::CSR_MAX_ITER,   efi_pkg::CSR_DATA_W'(efi_pkg::RST_MAX_ITER));
      write_csr(efi_pkg::CSR_VARIANT,    efi_pkg::CSR_DATA_W'(efi_pkg::RST_VARIANT));
      write_csr(efi_pkg::CSR_POWER_COEF, efi_pkg::CSR_DATA_W'(efi_pkg::RST_POWER_COEF));
      write_csr(efi_pkg::CSR_ORIGIN_RE,  efi_pkg::RST_ORIGIN_RE);
      write_csr(efi_pkg::CSR_ORIGIN_IM,  efi_pkg::RST_ORIGIN_IM);
      write_csr(efi_pkg::CSR_PIXEL_STEP, efi_pkg::CSR_DATA_W'(efi_pkg::RST_PIXEL_STEP));
   endtask

   // Offer one pixel request, starting at a rising edge. Valid stays high
   // after acceptance unless a gap follows, so back-to-back requests never
   // drop valid for a step.
   task automatic send_pixel(input logic [efi_pkg::PIX_W-1:0] px,
                             input logic [efi_pkg::PIX_W-1:0] py);
      efi_pkg::req_payload_type item;
      int                       gap;
      item.pixel_x = px;
      item.pixel_y = py;
      req_payload <= item;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_counts.push_back(escape_count(px, py));
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid, wait for every pending result, then let the block settle
   // so register writes land while it is idle.
   task automatic settle_idle();
      if (req_valid) req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Result side: random backpressure and the checker
   // ------------------------------------------------------------------

   // Each decision sets rsp_stall once and holds it for a counted span.
   initial begin : result_backpressure
      int   span;
      logic hold;
      @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            hold            = 1'b1;
            span            = hold_off_cycles;
            hold_off_cycles = 0;
         end else if (steady_flow) begin
            hold = 1'b0;
            span = 1;
         end else begin
            hold = ($urandom_range(0, 99) < 35);
            span = hold ? pick_gap() + 1 : $urandom_range(1, 12);
         end
         rsp_stall <= hold;
         repeat (span) @(posedge clock);
      end
   end

   // Sampled in the active region of the edge, so values are pre-edge.
   initial begin : result_checker
      efi_pkg::rsp_payload_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               flag_mismatch("result with no request pending");
            end else begin
               want = expected_counts.pop_front();
               if (rsp_payload.iteration_count !== want.iteration_count)
                  flag_mismatch($sformatf("iteration_count got %0d want %0d",
                                          rsp_payload.iteration_count,
                                          want.iteration_count));
               if (rsp_payload.in_set !== want.in_set)
                  flag_mismatch($sformatf("in_set got %0b want %0b (count %0d)",
                                          rsp_payload.in_set, want.in_set,
                                          want.iteration_count));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset register values, corners of the pixel range, one point in the set.
   task automatic test_reset_defaults();
      send_pixel(16'd0, 16'd0);          // c = -2 - 1i, escapes after one step
      send_pixel(16'd446, 16'd297);      // c near -0.5, stays in the set
      send_pixel(16'hFFFF, 16'hFFFF);    // c saturates high on both axes
      send_pixel(16'd0, 16'hFFFF);
      send_pixel(16'hFFFF, 16'd0);
      settle_idle();
   endtask

   // Every variant code, including the spare one.
   task automatic test_variants();
      logic [efi_pkg::VAR_W-1:0] codes[4];
      codes = '{efi_pkg::VARIANT_MANDEL, efi_pkg::VARIANT_SHIP,
                efi_pkg::VARIANT_TRICORN, VARIANT_SPARE};
      foreach (codes[k]) begin
         write_csr(efi_pkg::CSR_VARIANT, efi_pkg::CSR_DATA_W'(codes[k]));
         send_pixel(16'd446, 16'd297);
         send_pixel(16'd330, 16'd160);
         settle_idle();
      end
      write_csr(efi_pkg::CSR_VARIANT, efi_pkg::CSR_DATA_W'(efi_pkg::RST_VARIANT));
   endtask

   // Limit of zero, the limit hit just before an escape, the largest limit.
   task automatic test_iteration_limits();
      write_csr(efi_pkg::CSR_MAX_ITER, 32'd0);
      send_pixel(16'd446, 16'd297);      // no iteration at all, flagged in set
      settle_idle();
      write_csr(efi_pkg::CSR_MAX_ITER, 32'd1);
      send_pixel(16'd0, 16'd0);          // would escape next, but limit is hit
      settle_idle();
      write_csr(efi_pkg::CSR_MAX_ITER, 32'd1023);
      send_pixel(16'd446, 16'd297);
      send_pixel(16'd200, 16'd150);
      settle_idle();
      write_csr(efi_pkg::CSR_MAX_ITER, efi_pkg::CSR_DATA_W'(efi_pkg::RST_MAX_ITER));
   endtask

   // Coefficient and origin/step extremes, plus writes to unmapped indexes.
   task automatic test_coef_and_saturation();
      write_csr(efi_pkg::CSR_POWER_COEF, 32'd0);
      send_pixel(16'd446, 16'd297);
      send_pixel(16'd300, 16'd200);
      settle_idle();
      // ~16x cross term drives z_imag into saturation near |z| = 2
      write_csr(efi_pkg::CSR_POWER_COEF, 32'h0000_FFFF);
      send_pixel(16'd400, 16'd330);
      settle_idle();
      write_csr(efi_pkg::CSR_POWER_COEF, efi_pkg::CSR_DATA_W'(efi_pkg::RST_POWER_COEF));
      write_csr(efi_pkg::CSR_ORIGIN_RE, 32'h8000_0000);
      write_csr(efi_pkg::CSR_ORIGIN_IM, 32'h7FFF_FFFF);
      write_csr(efi_pkg::CSR_PIXEL_STEP, 32'd0);
      send_pixel(16'd12345, 16'd54321);
      settle_idle();
      // bit 31 of the data is not part of the step
      write_csr(efi_pkg::CSR_PIXEL_STEP, 32'hFFFF_FFFF);
      send_pixel(16'hFFFF, 16'hFFFF);
      send_pixel(16'd1, 16'd0);
      settle_idle();
      // unmapped writes must leave the default set untouched
      load_defaults();
      write_csr(CSR_UNMAPPED_A, 32'hDEAD_BEEF);
      write_csr(CSR_UNMAPPED_B, 32'h0000_0000);
      send_pixel(16'd446, 16'd297);
      send_pixel(16'd330, 16'd160);
      settle_idle();
   endtask

   // A stretch with no idling on either side.
   task automatic test_back_to_back();
      steady_flow = 1'b1;
      repeat (40) send_pixel(random_pixel(), random_pixel());
      settle_idle();
      steady_flow = 1'b0;
   endtask

   // Result side holds off for a long time while requests keep coming,
   // so the block fills up and stalls its request side.
   task automatic test_result_hold_off();
      hold_off_cycles = 400;
      repeat (16) send_pixel(random_pixel(), random_pixel());
      settle_idle();
   endtask

   // Random frames: each phase loads a new register set, then sends pixels.
   // Limits stay moderate so the run length stays bounded.
   task automatic test_random_frames();
      logic [efi_pkg::CSR_DATA_W-1:0] junk;
      int                             roll;
      for (int phase = 0; phase < 14; phase++) begin
         roll = $urandom_range(0, 9);
         junk = $urandom();
         if (roll == 0) junk[efi_pkg::ITER_W-1:0] = efi_pkg::ITER_W'($urandom_range(1, 4));
         else if (roll < 7)
            junk[efi_pkg::ITER_W-1:0] = efi_pkg::ITER_W'($urandom_range(16, 128));
         else junk[efi_pkg::ITER_W-1:0] = efi_pkg::ITER_W'($urandom_range(1, 255));
         write_csr(efi_pkg::CSR_MAX_ITER, junk);

         junk = $urandom();
         junk[efi_pkg::VAR_W-1:0] = efi_pkg::VAR_W'($urandom_range(0, 3));
         write_csr(efi_pkg::CSR_VARIANT, junk);

         roll = $urandom_range(0, 9);
         junk = $urandom();
         if (roll == 0) junk[efi_pkg::COEF_W-1:0] = '0;
         else if (roll == 1) junk[efi_pkg::COEF_W-1:0] = '1;
         else if (roll > 3)
            junk[efi_pkg::COEF_W-1:0] = efi_pkg::COEF_W'($urandom_range(4096, 12288));
         write_csr(efi_pkg::CSR_POWER_COEF, junk);

         // frame mostly around the interesting part of the plane
         if ($urandom_range(0, 9) == 0) write_csr(efi_pkg::CSR_ORIGIN_RE, $urandom());
         else write_csr(efi_pkg::CSR_ORIGIN_RE, -167772160 + $urandom_range(0, 67108864));
         if ($urandom_range(0, 9) == 0) write_csr(efi_pkg::CSR_ORIGIN_IM, $urandom());
         else write_csr(efi_pkg::CSR_ORIGIN_IM, -100663296 + $urandom_range(0, 67108864));

         roll = $urandom_range(0, 9);
         junk = $urandom();
         if (roll != 0)
            junk[efi_pkg::STEP_W-1:0] = efi_pkg::STEP_W'($urandom_range(1 << 18, 1 << 20));
         write_csr(efi_pkg::CSR_PIXEL_STEP, junk);

         repeat (100) send_pixel(random_pixel(), random_pixel());
         settle_idle();
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin : main_sequence
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_variants();
      test_iteration_limits();
      test_coef_and_saturation();
      test_back_to_back();
      test_result_hold_off();
      test_random_frames();

      settle_idle();
      if (mismatch_count == 0) begin
         $display("escape_time_fractal_iterator_top_test: clean");
      end else begin
         $display("escape_time_fractal_iterator_top_test: errors");
      end
      $finish;
   end

endmodule
